[rtl/bdq_pkg.sv]
`timescale 1ns / 1ps

package bdq_pkg;

  // queue geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // port field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned WORD_W = 32;

  // requested action of one input word
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_TAIL = 2'd0,
    ACT_PUSH_HEAD = 2'd1,
    ACT_POP_TAIL  = 2'd2,
    ACT_POP_HEAD  = 2'd3
  } action_e;

  // result status
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // what a cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_TAKE_PREV = 2'd1,
    CELL_TAKE_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

[rtl/bdq_cell.sv]
`timescale 1ns / 1ps

module bdq_cell
  import bdq_pkg::*;
(
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] prev_data_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  input  logic [DATA_WIDTH-1:0] load_data_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  // pick the source of this entry
  always_comb begin
    unique case (ctrl_i.op)
      CELL_TAKE_PREV: data_d = prev_data_i;
      CELL_TAKE_NEXT: data_d = next_data_i;
      CELL_LOAD:      data_d = load_data_i;
      default:        data_d = data_q;
    endcase
  end

  // entry storage, payload only
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/bdq_ctrl.sv]
`timescale 1ns / 1ps

module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic             accept_i,
  input  action_e          action_i,
  input  logic [CNT_W-1:0] count_i,
  output cell_ctrl_t       cell_ctrl_o [DEPTH],
  output logic [CNT_W-1:0] count_d_o,
  output status_e          status_o
);

  logic is_full, is_empty;

  assign is_full  = (count_i == CNT_W'(DEPTH));
  assign is_empty = (count_i == '0);

  // status, new fill count and per-cell shift/load commands
  always_comb begin
    count_d_o = count_i;
    status_o  = STAT_DONE;
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl_o[i].op = CELL_HOLD;
    end
    unique case (action_i)
      ACT_PUSH_TAIL: begin
        if (is_full) begin
          status_o = STAT_FULL;
        end else if (accept_i) begin
          count_d_o = count_i + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (count_i == CNT_W'(i)) cell_ctrl_o[i].op = CELL_LOAD;
          end
        end
      end
      ACT_PUSH_HEAD: begin
        if (is_full) begin
          status_o = STAT_FULL;
        end else if (accept_i) begin
          count_d_o = count_i + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl_o[i].op = CELL_TAKE_PREV;
          end
        end
      end
      ACT_POP_TAIL: begin
        if (is_empty) begin
          status_o = STAT_EMPTY;
        end else if (accept_i) begin
          count_d_o = count_i - CNT_W'(1);
        end
      end
      default: begin
        if (is_empty) begin
          status_o = STAT_EMPTY;
        end else if (accept_i) begin
          count_d_o = count_i - CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl_o[i].op = CELL_TAKE_NEXT;
          end
        end
      end
    endcase
  end

endmodule

[rtl/bounded_deque_core.sv]
`timescale 1ns / 1ps
// result: a result word is registered and valid in the cycle after its input word is taken
// throughput: one word per cycle; a new word is taken whenever the output
//   register is empty or being drained in the same cycle
// reset: fill count, output valid and status clear; entry cells keep
//   garbage until written, which is never observable

module bounded_deque_core
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic [LEN_W-1:0]         length_o,
  output logic signed [WORD_W-1:0] head_value_o,
  output logic signed [WORD_W-1:0] tail_value_o
);

  logic                  accept;
  logic [CNT_W-1:0]      count_d, count_q;
  logic                  out_valid_d, out_valid_q;
  status_e               status_d, status_q;
  cell_ctrl_t            cell_ctrl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] prev_data [DEPTH];
  logic [DATA_WIDTH-1:0] next_data [DEPTH];
  logic [DATA_WIDTH-1:0] push_data;
  logic [CNT_W-1:0]      tail_pos;
  logic [DATA_WIDTH-1:0] tail_raw;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_data  = value_i[DATA_WIDTH-1:0];

  bdq_ctrl u_ctrl (
    .accept_i    (accept),
    .action_i    (action_e'(action_i)),
    .count_i     (count_q),
    .cell_ctrl_o (cell_ctrl),
    .count_d_o   (count_d),
    .status_o    (status_d)
  );

  // neighbor wiring of the cell row, head at cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_data[g] = push_data;
    end else begin : g_mid
      assign prev_data[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_data[g] = cell_data[g];
    end else begin : g_inner
      assign next_data[g] = cell_data[g+1];
    end

    bdq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .prev_data_i (prev_data[g]),
      .next_data_i (next_data[g]),
      .load_data_i (push_data),
      .data_o      (cell_data[g])
    );
  end

  // output word control
  assign out_valid_d = accept ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STAT_DONE;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (accept) status_q <= status_d;
    end
  end

  // head and tail read straight from the row; state only moves on accept
  assign tail_pos = count_q - CNT_W'(1);
  assign tail_raw = cell_data[tail_pos[IDX_W-1:0]];

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign length_o     = LEN_W'(count_q);
  assign head_value_o = (count_q == '0) ? '0 : WORD_W'(signed'(cell_data[0]));
  assign tail_value_o = (count_q == '0) ? '0 : WORD_W'(signed'(tail_raw));

  // checks
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_full_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STAT_FULL) |-> count_q == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_empty_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STAT_EMPTY) |-> count_q == '0)
    else $error("empty status with entries held");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_PUSH_TAIL || action_i == ACT_PUSH_HEAD)
      && count_q != CNT_W'(DEPTH)) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the queue");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bdq_pkg::*;

  // one result word as the block reports it
  typedef struct packed {
    status_e                  status;
    logic [LEN_W-1:0]         length;
    logic signed [WORD_W-1:0] head;
    logic signed [WORD_W-1:0] tail;
  } deque_result_t;

  // one directed stimulus row, with an optional hand-written expectation
  typedef struct packed {
    action_e          act;
    logic [WORD_W-1:0] val;
    logic             fixed;
    deque_result_t    res;
  } dir_row_t;

  // what the monitor needs to know about each offered word
  typedef struct packed {
    logic          fixed;
    deque_result_t res;
  } offer_t;

  localparam int unsigned N_RANDOM    = 800;
  localparam int unsigned QUIET_TAIL  = 120;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned N_DIRECTED  = 25;

  localparam logic signed [WORD_W-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] MINV = 32'sh8000_0000;
  localparam deque_result_t NO_FIX = '{STAT_DONE, 5'd0, 32'sh0, 32'sh0};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ACT_W-1:0]         action_i;
  logic signed [WORD_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [STAT_W-1:0]        status_o;
  logic [LEN_W-1:0]         length_o;
  logic signed [WORD_W-1:0] head_value_o;
  logic signed [WORD_W-1:0] tail_value_o;

  // mirror of the ring contents and pointers
  logic [DATA_WIDTH-1:0] mirror_slots [DEPTH];
  int unsigned           mirror_front;
  int unsigned           mirror_back;
  int unsigned           mirror_count;

  offer_t        offered_words [$];
  deque_result_t pending_results [$];

  int unsigned words_sent;
  int unsigned words_taken;
  int unsigned results_seen;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          quiet;
  bit          hold_request;

  // directed walk: empty pops, extremes, fill to full, pushes on full
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_POP_HEAD,  32'h0000_0000, 1'b1, '{STAT_EMPTY, 5'd0, 32'sh0, 32'sh0}},
    '{ACT_POP_TAIL,  32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY, 5'd0, 32'sh0, 32'sh0}},
    '{ACT_PUSH_TAIL, MAXV,          1'b1, '{STAT_DONE,  5'd1, MAXV, MAXV}},
    '{ACT_PUSH_HEAD, MINV,          1'b1, '{STAT_DONE,  5'd2, MINV, MAXV}},
    '{ACT_POP_TAIL,  32'h0000_0000, 1'b1, '{STAT_DONE,  5'd1, MINV, MINV}},
    '{ACT_POP_HEAD,  32'h0000_0000, 1'b1, '{STAT_DONE,  5'd0, 32'sh0, 32'sh0}},
    '{ACT_PUSH_TAIL, 32'hFFFF_FFFF, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h0000_0000, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'h0000_0001, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h5555_5555, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'hAAAA_AAAA, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, MAXV,          1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, MINV,          1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h0000_FFFF, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'hFFFF_0000, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h1234_5678, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'h8000_0001, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h7FFF_FFFE, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'h0F0F_0F0F, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'hF0F0_F0F0, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'h1357_9BDF, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h2468_ACE0, 1'b0, NO_FIX},
    '{ACT_PUSH_TAIL, 32'h1111_1111, 1'b0, NO_FIX},
    '{ACT_PUSH_HEAD, 32'h2222_2222, 1'b0, NO_FIX},
    '{ACT_POP_HEAD,  32'h0000_0000, 1'b0, NO_FIX}
  };

  bounded_deque_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .length_o     (length_o),
    .head_value_o (head_value_o),
    .tail_value_o (tail_value_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stored entry widened to the port width with its sign
  function automatic logic signed [WORD_W-1:0] to_word(input logic signed [DATA_WIDTH-1:0] s);
    return s;
  endfunction

  // apply one action to the mirror and return the word the block should report
  function automatic deque_result_t deque_apply(input action_e act,
                                                input logic [WORD_W-1:0] val);
    deque_result_t r;
    r.status = STAT_DONE;
    case (act)
      ACT_PUSH_TAIL: begin
        if (mirror_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          mirror_slots[mirror_back] = val[DATA_WIDTH-1:0];
          mirror_back  = (mirror_back + 1) % DEPTH;
          mirror_count = mirror_count + 1;
        end
      end
      ACT_PUSH_HEAD: begin
        if (mirror_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          mirror_slots[mirror_front] = val[DATA_WIDTH-1:0];
          mirror_count = mirror_count + 1;
        end
      end
      ACT_POP_TAIL: begin
        if (mirror_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          mirror_back  = (mirror_back + DEPTH - 1) % DEPTH;
          mirror_count = mirror_count - 1;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          mirror_front = (mirror_front + 1) % DEPTH;
          mirror_count = mirror_count - 1;
        end
      end
    endcase
    r.length = LEN_W'(mirror_count);
    if (mirror_count == 0) begin
      r.head = '0;
      r.tail = '0;
    end else begin
      r.head = to_word(mirror_slots[mirror_front]);
      r.tail = to_word(mirror_slots[(mirror_back + DEPTH - 1) % DEPTH]);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch on result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // offer one word and hold it until the block takes it
  task automatic send_word(input action_e act, input logic [WORD_W-1:0] val,
                           input logic fixed, input deque_result_t res);
    offer_t o;
    o.fixed = fixed;
    o.res   = res;
    offered_words.push_back(o);
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // random idle burst on the input side
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // handshake monitor: check results, then predict for newly taken words
  always @(posedge clk_i) begin : monitor
    deque_result_t got;
    deque_result_t want;
    offer_t        o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_e'(status_o), length_o, head_value_o, tail_value_o};
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
          if (got.head !== want.head)
            report_mismatch($sformatf("head %0d, expected %0d", got.head, want.head));
          if (got.tail !== want.tail)
            report_mismatch($sformatf("tail %0d, expected %0d", got.tail, want.tail));
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        o    = offered_words.pop_front();
        want = deque_apply(action_e'(action_i), value_i);
        if (want.status == STAT_FULL) full_hits++;
        if (want.status == STAT_EMPTY) empty_hits++;
        if (o.fixed) want = o.res;
        pending_results.push_back(want);
        words_taken++;
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb_top: no handshake for %0d cycles", STALL_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: random ready bursts, one long hold-off to back up the block
  initial begin
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  // reset, directed table, random phase, drain and verdict
  initial begin
    action_e               act;
    logic [WORD_W-1:0]     val;
    int unsigned           mode;
    int unsigned           mode_left;
    int unsigned           pick;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_PUSH_TAIL;
    value_i      = '0;
    mirror_front = 0;
    mirror_back  = 0;
    mirror_count = 0;
    words_sent   = 0;
    words_taken  = 0;
    results_seen = 0;
    full_hits    = 0;
    empty_hits   = 0;
    mismatches   = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    mode         = 0;
    mode_left    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(directed_rows[i].act, directed_rows[i].val,
                directed_rows[i].fixed, directed_rows[i].res);
      sender_gap();
    end

    // random walk that alternates between filling, draining and balanced phases
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_request = 1'b1;
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(24, 48);
      end
      mode_left--;
      pick = $urandom_range(0, 3);
      case (mode)
        0:       act = (pick != 0) ? ACT_PUSH_TAIL : ACT_POP_TAIL;
        1:       act = (pick != 0) ? ACT_POP_TAIL : ACT_PUSH_TAIL;
        default: act = (pick[0]) ? ACT_PUSH_TAIL : ACT_POP_TAIL;
      endcase
      // pick the end of the deque at random
      if ($urandom_range(0, 1) == 1)
        act = (act == ACT_PUSH_TAIL) ? ACT_PUSH_HEAD : ACT_POP_HEAD;
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        2:       val = MAXV;
        3:       val = MINV;
        default: val = $urandom;
      endcase
      send_word(act, val, 1'b0, NO_FIX);
      sender_gap();
    end
    in_valid_i <= 1'b0;

    // drain, then give stray words a chance to show up
    while (pending_results.size() != 0 || words_taken != words_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d words taken, %0d results checked, %0d mismatches",
             words_taken, results_seen, mismatches);
    $display("tb_top: %0d pushes refused on full, %0d pops refused on empty",
             full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
